[rtl/core/iips_pkg.sv]
// shared types and constants for the in-order issue port scheduler
package iips_pkg;

    localparam int KIND_W     = 3;
    localparam int IDX_W      = 9;
    localparam int PCNT_W     = 4;
    localparam int OUT_W      = 16;
    localparam int PORT_W     = 3;
    localparam int LAT_W      = 4;
    localparam int USED_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int PRED_PORTS = 8;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD   = 3'd0,
        OP_NEG   = 3'd1,
        OP_MUL   = 3'd2,
        OP_FMA   = 3'd3,
        OP_LOAD  = 3'd4,
        OP_CONST = 3'd5,
        OP_CMUL  = 3'd6
    } t_op_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUL_FMA_PORTS = 3'd0,
        CFG_FLOAT_PORTS   = 3'd1,
        CFG_LOAD_PORTS    = 3'd2,
        CFG_LOAD_LATENCY  = 3'd3,
        CFG_OP_LATENCY    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MERGE = 2'd1,
        ST_ISSUE = 2'd2
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lane_ctrl;

    localparam logic [PORT_W-1:0] MUL_PORTS_RST   = 3'd2;
    localparam logic [PORT_W-1:0] FLOAT_PORTS_RST = 3'd3;
    localparam logic [PORT_W-1:0] LOAD_PORTS_RST  = 3'd3;
    localparam logic [LAT_W-1:0]  LOAD_LAT_RST    = 4'd5;
    localparam logic [LAT_W-1:0]  OP_LAT_RST      = 4'd4;

    localparam logic [PORT_W-1:0] MUL_PORTS_MIN   = 3'd2;
    localparam logic [PORT_W-1:0] FLOAT_PORTS_MIN = 3'd2;
    localparam logic [PORT_W-1:0] LOAD_PORTS_MIN  = 3'd1;

    localparam logic [USED_W-1:0] USED_MAX        = 3'd7;

endpackage

[rtl/core/inorder_issue_port_scheduler.sv]
// top level of the in-order issue scheduler with per-cycle port limits
//
//  channel   valid        flow control   payload
//  item in   i_valid      o_stall        i_op_kind .. i_last_of_schedule
//  result    o_valid      i_stall        o_issue_cycle .. o_schedule_done
//  config    i_cfg_valid  o_cfg_ready    i_cfg_index, i_cfg_data
//
// each item passes lane read, max tree and issue step before o_stall lets the next one in
// the lanes read all predecessors in the accept cycle, the max tree adds one register per level
// the issue step does the port check and the finish table write-back
// reset is synchronous; the finish table holds no reset state
// a stalled result holds the next item in its issue step until the output register frees
module inorder_issue_port_scheduler
    import iips_pkg::*;
#(
    parameter int NODES     = 512,
    parameter int MAX_PREDS = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [KIND_W-1:0]     i_op_kind,
    input  logic [IDX_W-1:0]      i_node_index,
    input  logic [PCNT_W-1:0]     i_pred_count,
    input  logic [IDX_W-1:0]      i_pred_a,
    input  logic [IDX_W-1:0]      i_pred_b,
    input  logic [IDX_W-1:0]      i_pred_c,
    input  logic [IDX_W-1:0]      i_pred_d,
    input  logic [IDX_W-1:0]      i_pred_e,
    input  logic [IDX_W-1:0]      i_pred_f,
    input  logic [IDX_W-1:0]      i_pred_g,
    input  logic [IDX_W-1:0]      i_pred_h,
    input  logic                  i_last_of_schedule,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_issue_cycle,
    output logic [OUT_W-1:0]      o_finish_cycle,
    output logic [OUT_W-1:0]      o_makespan,
    output logic                  o_schedule_done,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LEAVES = MAX_PREDS + 1;
    localparam int LEVELS = $clog2(LEAVES);
    localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    function automatic logic [NODE_W-1:0] node_wrap(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] v;
        v = idx;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if ((longint'(NODES) << k) < (longint'(1) << IDX_W)) begin
                if (v >= IDX_W'(NODES << k)) begin
                    v = v - IDX_W'(NODES << k);
                end
            end
        end
        return NODE_W'(v);
    endfunction

    function automatic logic [USED_W-1:0] used_sat(input logic [USED_W:0] s);
        return (s > (USED_W+1)'(USED_MAX)) ? USED_MAX : s[USED_W-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [WAIT_W-1:0]    r_wait, n_wait;
    logic                 w_in_acc;
    logic                 w_issue_go;
    t_lane_ctrl           w_lane_ctrl;

    logic [PORT_W-1:0]    r_mul_ports, r_float_ports, r_load_ports;
    logic [LAT_W-1:0]     r_load_lat, r_op_lat;

    logic [KIND_W-1:0]    r_kind;
    logic [NODE_W-1:0]    r_node;
    logic                 r_last_item;

    logic [TIME_BITS-1:0] r_last_issue;
    logic [USED_W-1:0]    r_mul_used, r_float_used, r_loads_used;
    logic [TIME_BITS-1:0] r_mk;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_issue, r_finish, r_makespan;
    logic                 r_done;

    logic [IDX_W-1:0]     w_pred [PRED_PORTS];
    logic [TIME_BITS-1:0] w_leaf [LEAVES];
    logic [TIME_BITS-1:0] w_ready;

    logic [1:0]           w_um, w_uf;
    logic                 w_is_load, w_is_const;
    logic [PORT_W-1:0]    w_lim_m, w_lim_f, w_lim_l;
    logic                 w_full, w_adv, w_fresh;
    logic [TIME_BITS-1:0] w_t2;
    logic [LAT_W-1:0]     w_lat;
    logic [TIME_BITS:0]   w_fin_sum;
    logic [TIME_BITS-1:0] w_fin, w_mk;
    logic [USED_W-1:0]    w_base_m, w_base_f, w_base_l;
    logic [USED_W-1:0]    w_new_m, w_new_f, w_new_l;

    // handshakes
    assign o_stall     = (r_state != ST_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_lane_ctrl.rd_en = w_in_acc;
    assign w_lane_ctrl.wr_en = w_issue_go;

    // predecessor lanes
    assign w_pred[0] = i_pred_a;
    assign w_pred[1] = i_pred_b;
    assign w_pred[2] = i_pred_c;
    assign w_pred[3] = i_pred_d;
    assign w_pred[4] = i_pred_e;
    assign w_pred[5] = i_pred_f;
    assign w_pred[6] = i_pred_g;
    assign w_pred[7] = i_pred_h;

    for (genvar g = 0; g < MAX_PREDS; g++) begin : g_lane
        iips_lane #(
            .NODES     (NODES),
            .TIME_BITS (TIME_BITS),
            .NODE_W    (NODE_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (w_lane_ctrl),
            .i_rd_addr (node_wrap(w_pred[g])),
            .i_rd_use  (i_pred_count > PCNT_W'(g)),
            .i_wr_addr (r_node),
            .i_wr_data (w_fin),
            .o_data    (w_leaf[g])
        );
    end

    assign w_leaf[MAX_PREDS] = r_last_issue;

    iips_merge #(
        .LEAVES    (LEAVES),
        .TIME_BITS (TIME_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_max  (w_ready)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_wait     = r_wait;
        w_issue_go = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MERGE;
                    n_wait  = '0;
                end
            end
            ST_MERGE: begin
                if (r_wait == WAIT_W'(LEVELS - 1)) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            ST_ISSUE: begin
                if (!r_out_valid || !i_stall) begin
                    w_issue_go = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind      <= i_op_kind;
            r_node      <= node_wrap(i_node_index);
            r_last_item <= i_last_of_schedule;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ports   <= MUL_PORTS_RST;
            r_float_ports <= FLOAT_PORTS_RST;
            r_load_ports  <= LOAD_PORTS_RST;
            r_load_lat    <= LOAD_LAT_RST;
            r_op_lat      <= OP_LAT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MUL_FMA_PORTS: r_mul_ports   <= i_cfg_data[PORT_W-1:0];
                CFG_FLOAT_PORTS:   r_float_ports <= i_cfg_data[PORT_W-1:0];
                CFG_LOAD_PORTS:    r_load_ports  <= i_cfg_data[PORT_W-1:0];
                CFG_LOAD_LATENCY:  r_load_lat    <= i_cfg_data[LAT_W-1:0];
                CFG_OP_LATENCY:    r_op_lat      <= i_cfg_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // uop demand per kind
    always_comb begin
        w_um       = 2'd0;
        w_uf       = 2'd0;
        w_is_load  = 1'b0;
        w_is_const = 1'b0;
        case (r_kind)
            OP_MUL, OP_FMA: begin
                w_um = 2'd1;
                w_uf = 2'd1;
            end
            OP_CMUL: begin
                w_um = 2'd2;
                w_uf = 2'd2;
            end
            OP_LOAD:  w_is_load  = 1'b1;
            OP_CONST: w_is_const = 1'b1;
            default:  w_uf = 2'd1;
        endcase
    end

    // port check, issue cycle and finish cycle
    always_comb begin
        w_lim_m = (r_mul_ports   < MUL_PORTS_MIN)   ? MUL_PORTS_MIN   : r_mul_ports;
        w_lim_f = (r_float_ports < FLOAT_PORTS_MIN) ? FLOAT_PORTS_MIN : r_float_ports;
        w_lim_l = (r_load_ports  < LOAD_PORTS_MIN)  ? LOAD_PORTS_MIN  : r_load_ports;

        if (w_is_load) begin
            w_full = (r_loads_used >= w_lim_l);
        end else begin
            w_full = ((USED_W+1)'(r_mul_used) + (USED_W+1)'(w_um) > (USED_W+1)'(w_lim_m))
                  || ((USED_W+1)'(r_float_used) + (USED_W+1)'(w_uf) > (USED_W+1)'(w_lim_f));
        end

        w_adv   = (w_ready == r_last_issue) && w_full && (w_ready != TMAX) && !w_is_const;
        w_t2    = w_ready + TIME_BITS'(w_adv);
        w_fresh = (w_t2 != r_last_issue);

        w_lat     = w_is_load ? r_load_lat : r_op_lat;
        w_fin_sum = (TIME_BITS+1)'(w_t2) + (TIME_BITS+1)'(w_lat);
        if (w_is_const) begin
            w_fin = w_ready;
        end else if (w_fin_sum[TIME_BITS]) begin
            w_fin = TMAX;
        end else begin
            w_fin = w_fin_sum[TIME_BITS-1:0];
        end
        w_mk = (w_fin > r_mk) ? w_fin : r_mk;

        w_base_m = w_fresh ? '0 : r_mul_used;
        w_base_f = w_fresh ? '0 : r_float_used;
        w_base_l = w_fresh ? '0 : r_loads_used;
        w_new_m  = used_sat((USED_W+1)'(w_base_m) + (USED_W+1)'(w_um));
        w_new_f  = used_sat((USED_W+1)'(w_base_f) + (USED_W+1)'(w_uf));
        w_new_l  = used_sat((USED_W+1)'(w_base_l) + (USED_W+1)'(w_is_load));
    end

    // schedule state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_issue <= '0;
            r_mul_used   <= '0;
            r_float_used <= '0;
            r_loads_used <= '0;
            r_mk         <= '0;
        end else if (w_issue_go) begin
            if (r_last_item) begin
                r_last_issue <= '0;
                r_mul_used   <= '0;
                r_float_used <= '0;
                r_loads_used <= '0;
                r_mk         <= '0;
            end else begin
                r_mk <= w_mk;
                if (!w_is_const) begin
                    r_last_issue <= w_t2;
                    r_mul_used   <= w_new_m;
                    r_float_used <= w_new_f;
                    r_loads_used <= w_new_l;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_issue_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue_go) begin
            r_issue    <= OUT_W'(w_t2);
            r_finish   <= OUT_W'(w_fin);
            r_makespan <= OUT_W'(w_mk);
            r_done     <= r_last_item;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_issue_cycle   = r_issue;
    assign o_finish_cycle  = r_finish;
    assign o_makespan      = r_makespan;
    assign o_schedule_done = r_done;

    // checks
    a_issue_after_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ##LEVELS (r_state == ST_ISSUE))
        else $error("item did not reach the issue step after the max tree");

    a_issue_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue_go && !r_last_item) |=> (r_last_issue >= $past(r_last_issue)))
        else $error("last issue cycle moved backwards");

    a_load_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue_go && !r_last_item && (r_kind == OP_LOAD)) |=> (r_loads_used != '0))
        else $error("issued load not counted in its cycle");

endmodule

[rtl/core/iips_lane.sv]
// one predecessor lane: private copy of the finish table and a registered read
module iips_lane
    import iips_pkg::*;
#(
    parameter int NODES     = 512,
    parameter int TIME_BITS = 16,
    parameter int NODE_W    = 9
) (
    input  logic                 i_clk,
    input  t_lane_ctrl           i_ctrl,
    input  logic [NODE_W-1:0]    i_rd_addr,
    input  logic                 i_rd_use,
    input  logic [NODE_W-1:0]    i_wr_addr,
    input  logic [TIME_BITS-1:0] i_wr_data,
    output logic [TIME_BITS-1:0] o_data
);

    logic [TIME_BITS-1:0] r_mem [NODES];
    logic [TIME_BITS-1:0] r_rd;
    logic                 r_use;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd  <= r_mem[i_rd_addr];
            r_use <= i_rd_use;
        end
    end

    // unused lanes drop out of the maximum
    assign o_data = r_use ? r_rd : '0;

endmodule

[rtl/core/iips_merge.sv]
// registered maximum tree over the lane results and the last issue cycle
module iips_merge
    import iips_pkg::*;
#(
    parameter int LEAVES    = 9,
    parameter int TIME_BITS = 16
) (
    input  logic                 i_clk,
    input  logic [TIME_BITS-1:0] i_leaf [LEAVES],
    output logic [TIME_BITS-1:0] o_max
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int P2     = 1 << LEVELS;
    localparam int INNER  = P2 - 1;

    logic [TIME_BITS-1:0] w_base  [P2];
    logic [TIME_BITS-1:0] w_inner [INNER];

    for (genvar g = 0; g < P2; g++) begin : g_base
        if (g < LEAVES) begin : g_leaf
            assign w_base[g] = i_leaf[g];
        end else begin : g_pad
            assign w_base[g] = '0;
        end
    end

    for (genvar n = 0; n < INNER; n++) begin : g_node
        logic [TIME_BITS-1:0] w_l;
        logic [TIME_BITS-1:0] w_r;
        logic [TIME_BITS-1:0] r_val;

        if (2 * n + 1 >= INNER) begin : g_from_base
            assign w_l = w_base[2 * n + 1 - INNER];
            assign w_r = w_base[2 * n + 2 - INNER];
        end else begin : g_from_inner
            assign w_l = w_inner[2 * n + 1];
            assign w_r = w_inner[2 * n + 2];
        end

        always_ff @(posedge i_clk) begin
            r_val <= (w_l >= w_r) ? w_l : w_r;
        end

        assign w_inner[n] = r_val;
    end

    assign o_max = w_inner[0];

endmodule
